FILE: hw/rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Command codes, status codes and item layout for the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int CMD_WIDTH    = 3;
	localparam int IO_VAL_WIDTH = 32;
	localparam int STAT_WIDTH   = 2;
	localparam int COUNT_WIDTH  = 9;
	localparam int EXT_WIDTH    = 64;

	// Item widths on the stream ports, padded to whole bytes
	localparam int IN_TDATA_WIDTH  = 40;
	localparam int OUT_TDATA_WIDTH = 48;

	localparam logic [CMD_WIDTH-1:0] CMD_PUSH_BACK  = 3'd0;
	localparam logic [CMD_WIDTH-1:0] CMD_PUSH_FRONT = 3'd1;
	localparam logic [CMD_WIDTH-1:0] CMD_POP_BACK   = 3'd2;
	localparam logic [CMD_WIDTH-1:0] CMD_POP_FRONT  = 3'd3;
	localparam logic [CMD_WIDTH-1:0] CMD_REMOVE     = 3'd4;
	localparam logic [CMD_WIDTH-1:0] CMD_CONTAINS   = 3'd5;

	localparam logic [STAT_WIDTH-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_WIDTH-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_WIDTH-1:0] STAT_FULL  = 2'd2;

endpackage

FILE: hw/rtl/bdq_ram.sv
// ----------------------------------------------------------------------------
// bdq_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hw/rtl/bounded_deque_with_search.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Bounded double-ended queue with remove-by-value and membership search.
// ----------------------------------------------------------------------------
// The block holds up to CAPACITY signed values in order, in a circular buffer
// kept in one RAM with a front pointer and an occupancy count. Each input item
// carries a command (push back, push front, pop back, pop front, remove the
// first matching value, test for a value) and a value; each item yields exactly
// one result item with the popped value, a hit flag, a status and the count
// after the command. A push into a full store is dropped with status full; a
// pop on an empty store returns zero with status empty. Pushes and unused
// codes go from the execute state to the done state; pops pass through a
// wait state for the RAM read data between them, unless the store is empty.
// Search and remove are driven by one comparator stepping through the RAM
// read port one entry per cycle: contains stops at the first match, and
// remove walks on past the match to the back of the store, moving each
// later entry one place forward through the same read port and the write
// port. The input is not ready while a command is being worked; a finished
// result waits in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
module bounded_deque_with_search #(
	parameter int CAPACITY    = 256,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// s_tdata: [2:0] command, [34:3] value_in, [39:35] zero
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [bdq_pkg::IN_TDATA_WIDTH-1:0]   s_tdata,
	// m_tdata: [31:0] value_out, [32] hit, [34:33] status, [43:35] count,
	//          [47:44] zero
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [bdq_pkg::OUT_TDATA_WIDTH-1:0]  m_tdata
);

	localparam int IW = $clog2(CAPACITY);
	localparam int OW = $clog2(CAPACITY + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_POPW  = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_SHIFT = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	// Add an offset to a slot and wrap at the capacity
	function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
	                                           input logic [OW-1:0] off);
		logic [IW+1:0] sum;
		sum = (IW+2)'(base) + (IW+2)'(off);
		if (sum >= (IW+2)'(CAPACITY)) begin
			sum = sum - (IW+2)'(CAPACITY);
		end
		return sum[IW-1:0];
	endfunction

	// Control and working registers
	logic [2:0]                          state_q, state_d;
	logic [bdq_pkg::CMD_WIDTH-1:0]       cmd_q, cmd_d;
	logic [VALUE_WIDTH-1:0]              val_q, val_d;
	logic [IW-1:0]                       front_q, front_d;
	logic [OW-1:0]                       occ_q, occ_d;
	logic [IW-1:0]                       ptr_q, ptr_d;   // slot of data arriving now
	logic [OW-1:0]                       idx_q, idx_d;   // its place from the front
	logic [IW-1:0]                       dst_q, dst_d;   // slot being refilled
	logic [bdq_pkg::IO_VAL_WIDTH-1:0]    res_value_q, res_value_d;
	logic                                res_hit_q, res_hit_d;
	logic [bdq_pkg::STAT_WIDTH-1:0]      res_status_q, res_status_d;
	logic                                out_valid_q;
	logic [bdq_pkg::OUT_TDATA_WIDTH-1:0] out_data_q;
	logic                                out_load;

	// RAM port signals
	logic                   ram_we;
	logic [IW-1:0]          ram_waddr;
	logic [VALUE_WIDTH-1:0] ram_wdata;
	logic [IW-1:0]          ram_raddr;
	logic [VALUE_WIDTH-1:0] ram_rdata;

	// Derived values
	logic signed [bdq_pkg::EXT_WIDTH-1:0] in_ext;
	logic [bdq_pkg::EXT_WIDTH-1:0]        rd_ext;
	logic [31:0]                          occ_ext;
	logic                                 is_full;
	logic                                 is_empty;
	logic                                 more;
	logic [IW-1:0]                        ptr_inc;
	logic [IW-1:0]                        front_inc;
	logic [IW-1:0]                        front_dec;
	logic [IW-1:0]                        back_slot;
	logic [IW-1:0]                        last_slot;
	logic [OW-1:0]                        idx_inc;

	// Sign-extend the incoming value, then keep the stored width
	assign in_ext = bdq_pkg::EXT_WIDTH'($signed(s_tdata[34:3]));
	// Stored values leave zero-extended and cut to the port width
	assign rd_ext = bdq_pkg::EXT_WIDTH'(ram_rdata);
	assign occ_ext = 32'(occ_q);

	assign is_full   = (occ_q == OW'(CAPACITY));
	assign is_empty  = (occ_q == '0);
	assign idx_inc   = idx_q + OW'(1);
	assign more      = (idx_inc < occ_q);
	assign ptr_inc   = (ptr_q == IW'(CAPACITY - 1)) ? '0 : ptr_q + IW'(1);
	assign front_inc = (front_q == IW'(CAPACITY - 1)) ? '0 : front_q + IW'(1);
	assign front_dec = (front_q == '0) ? IW'(CAPACITY - 1) : front_q - IW'(1);
	assign back_slot = wrap_add(front_q, occ_q);
	assign last_slot = wrap_add(front_q, occ_q - OW'(1));

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	always_comb begin
		state_d      = state_q;
		cmd_d        = cmd_q;
		val_d        = val_q;
		front_d      = front_q;
		occ_d        = occ_q;
		ptr_d        = ptr_q;
		idx_d        = idx_q;
		dst_d        = dst_q;
		res_value_d  = res_value_q;
		res_hit_d    = res_hit_q;
		res_status_d = res_status_q;
		ram_we       = 1'b0;
		ram_waddr    = dst_q;
		ram_wdata    = ram_rdata;
		ram_raddr    = ptr_inc;
		s_tready     = (state_q == ST_IDLE);

		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd_d        = s_tdata[2:0];
					val_d        = in_ext[VALUE_WIDTH-1:0];
					res_value_d  = '0;
					res_hit_d    = 1'b0;
					res_status_d = bdq_pkg::STAT_OK;
					state_d      = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_DONE;
				case (cmd_q)
					bdq_pkg::CMD_PUSH_BACK: begin
						if (is_full) begin
							res_status_d = bdq_pkg::STAT_FULL;
						end else begin
							ram_we    = 1'b1;
							ram_waddr = back_slot;
							ram_wdata = val_q;
							occ_d     = occ_q + OW'(1);
						end
					end
					bdq_pkg::CMD_PUSH_FRONT: begin
						if (is_full) begin
							res_status_d = bdq_pkg::STAT_FULL;
						end else begin
							ram_we    = 1'b1;
							ram_waddr = front_dec;
							ram_wdata = val_q;
							front_d   = front_dec;
							occ_d     = occ_q + OW'(1);
						end
					end
					bdq_pkg::CMD_POP_BACK: begin
						if (is_empty) begin
							res_status_d = bdq_pkg::STAT_EMPTY;
						end else begin
							ram_raddr = last_slot;
							occ_d     = occ_q - OW'(1);
							state_d   = ST_POPW;
						end
					end
					bdq_pkg::CMD_POP_FRONT: begin
						if (is_empty) begin
							res_status_d = bdq_pkg::STAT_EMPTY;
						end else begin
							ram_raddr = front_q;
							front_d   = front_inc;
							occ_d     = occ_q - OW'(1);
							state_d   = ST_POPW;
						end
					end
					bdq_pkg::CMD_REMOVE, bdq_pkg::CMD_CONTAINS: begin
						// Start the walk at the front entry
						if (!is_empty) begin
							ram_raddr = front_q;
							ptr_d     = front_q;
							idx_d     = '0;
							state_d   = ST_SCAN;
						end
					end
					default: begin
					end
				endcase
			end
			ST_POPW: begin
				res_value_d = rd_ext[bdq_pkg::IO_VAL_WIDTH-1:0];
				state_d     = ST_DONE;
			end
			ST_SCAN: begin
				// Compare the arriving entry; the next one is already being read
				if (ram_rdata == val_q) begin
					res_hit_d = 1'b1;
					state_d   = ST_DONE;
					if (cmd_q == bdq_pkg::CMD_REMOVE) begin
						if (more) begin
							dst_d   = ptr_q;
							ptr_d   = ptr_inc;
							idx_d   = idx_inc;
							state_d = ST_SHIFT;
						end else begin
							occ_d = occ_q - OW'(1);
						end
					end
				end else if (more) begin
					ptr_d = ptr_inc;
					idx_d = idx_inc;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SHIFT: begin
				// Move the arriving entry one place towards the front
				ram_we = 1'b1;
				if (more) begin
					dst_d = ptr_q;
					ptr_d = ptr_inc;
					idx_d = idx_inc;
				end else begin
					occ_d   = occ_q - OW'(1);
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold control state under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			front_q     <= '0;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			occ_q   <= occ_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working and payload registers
	always_ff @(posedge clk) begin
		cmd_q        <= cmd_d;
		val_q        <= val_d;
		ptr_q        <= ptr_d;
		idx_q        <= idx_d;
		dst_q        <= dst_d;
		res_value_q  <= res_value_d;
		res_hit_q    <= res_hit_d;
		res_status_q <= res_status_d;
		if (out_load) begin
			out_data_q <= {4'b0000, occ_ext[bdq_pkg::COUNT_WIDTH-1:0], res_status_q,
			               res_hit_q, res_value_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	bdq_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (CAPACITY)
	) u_entries (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

FILE: sim/tb_bounded_deque_with_search.sv
// ----------------------------------------------------------------------------
// tb_bounded_deque_with_search
// Self-checking stream testbench for the bounded deque with search.
// ----------------------------------------------------------------------------
// Commands go in on the slave stream and results come out on the master
// stream. A mirror object keeps its own copy of the stored values in a
// queue. It works out the result of every command at the moment the command
// item is accepted. Each result item is then checked field by field against
// the oldest awaited result.
//
// A short directed run comes first. It covers pops and searches on an empty
// store, a push at the front of an empty store, removal from the middle and
// from the front, duplicates, the value extremes and the unused codes. The
// random part then does three things in turn: it fills the store past full,
// drains it past empty, and finishes with a balanced mix.
//
// Both sides idle at random. Most gaps are short and a few are long. There
// are also stretches with no idling at all.
// ----------------------------------------------------------------------------
module tb_bounded_deque_with_search;
	timeunit 1ns;
	timeprecision 1ps;

	import bdq_pkg::*;

	localparam int DEPTH          = 256;
	localparam int RANDOM_ITEMS   = 900;
	localparam int SETTLE_CYCLES  = 300;	// longer than a remove on a full store
	localparam int WATCHDOG_LIMIT = 4000;

	// Codes the block must treat as no-ops
	localparam logic [CMD_WIDTH-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [CMD_WIDTH-1:0] CMD_SPARE_7 = 3'd7;

	typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} cmd_mix_t;

	typedef struct {
		logic signed [IO_VAL_WIDTH-1:0] value;
		logic                           hit;
		logic [STAT_WIDTH-1:0]          status;
		logic [COUNT_WIDTH-1:0]         count;
	} deque_result_t;

	// ------------------------------------------------------------------------
	// Mirror of the store: predicts each result and holds the awaited ones
	// ------------------------------------------------------------------------
	class deque_mirror;
		logic signed [IO_VAL_WIDTH-1:0] shadow[$];
		deque_result_t                  awaited[$];
		int unsigned                    mismatches;

		function new();
			mismatches = 0;
		endfunction

		// Apply one accepted command to the shadow copy and queue its result
		function void note_command(logic [CMD_WIDTH-1:0] cmd,
				logic signed [IO_VAL_WIDTH-1:0] value);
			deque_result_t res;
			int            where;
			res.value  = '0;
			res.hit    = 1'b0;
			res.status = STAT_OK;
			where      = -1;
			// The first match counts from the front
			for (int i = 0; i < shadow.size(); i++)
				if (where < 0 && shadow[i] == value)
					where = i;
			case (cmd)
				CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
					if (shadow.size() >= DEPTH)
						res.status = STAT_FULL;	// drop the value
					else if (cmd == CMD_PUSH_BACK)
						shadow.push_back(value);
					else
						shadow.push_front(value);
				end
				CMD_POP_BACK, CMD_POP_FRONT: begin
					if (shadow.size() == 0)
						res.status = STAT_EMPTY;
					else if (cmd == CMD_POP_BACK)
						res.value = shadow.pop_back();
					else
						res.value = shadow.pop_front();
				end
				CMD_REMOVE: begin
					if (where >= 0) begin
						shadow.delete(where);	// later values close the gap
						res.hit = 1'b1;
					end
				end
				CMD_CONTAINS: begin
					res.hit = (where >= 0);
				end
				default: begin
				end
			endcase
			res.count = COUNT_WIDTH'(shadow.size());
			awaited.push_back(res);
		endfunction

		task report(string what, longint got, longint want);
			mismatches++;
			$display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		endtask

		// Compare one result item with the oldest awaited result
		task check_result(logic [OUT_TDATA_WIDTH-1:0] data);
			deque_result_t want;
			if (awaited.size() == 0) begin
				report("result item with nothing awaited, count", data[43:35], -1);
				return;
			end
			want = awaited.pop_front();
			if (data[31:0] !== want.value)
				report("value_out", $signed(data[31:0]), want.value);
			if (data[32] !== want.hit)
				report("hit", data[32], want.hit);
			if (data[34:33] !== want.status)
				report("status", data[34:33], want.status);
			if (data[43:35] !== want.count)
				report("count", data[43:35], want.count);
		endtask
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and the block
	// ------------------------------------------------------------------------
	logic                       clk;
	logic                       arst_n   = 1'b0;
	logic                       s_tvalid = 1'b0;
	logic                       s_tready;
	logic [IN_TDATA_WIDTH-1:0]  s_tdata  = '0;	// [2:0] command, [34:3] value_in
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	// [31:0] value_out, [32] hit, [34:33] status, [43:35] count
	logic [OUT_TDATA_WIDTH-1:0] m_tdata;

	deque_mirror board;
	bit          steady = 1'b0;	// when set, neither side idles
	int          random_items = 0;
	int unsigned quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	bounded_deque_with_search dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// ------------------------------------------------------------------------
	// Random helpers
	// ------------------------------------------------------------------------
	// Idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Values from a small pool make duplicates; the rest span all 32 bits
	function automatic logic signed [IO_VAL_WIDTH-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2, 3, 4: return $signed($urandom_range(0, 7)) - 4;
			default: return $urandom;
		endcase
	endfunction

	// Search key: usually a stored value, so that removes and searches hit
	function automatic logic signed [IO_VAL_WIDTH-1:0] pick_target();
		if (board.shadow.size() != 0 && $urandom_range(0, 9) < 6)
			return board.shadow[$urandom_range(0, board.shadow.size() - 1)];
		return pick_value();
	endfunction

	// ------------------------------------------------------------------------
	// Drive the slave side: idle for a while, then offer one item and hold it
	// until it is accepted. Keep tvalid high when no gap follows.
	// ------------------------------------------------------------------------
	task automatic send_item(logic [CMD_WIDTH-1:0] cmd, logic signed [IO_VAL_WIDTH-1:0] value);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_TDATA_WIDTH - CMD_WIDTH - IO_VAL_WIDTH){1'b0}}, value, cmd};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_command(cmd, value);
	endtask

	// Draw one command with the weights of the current mix
	task automatic random_item(cmd_mix_t mix);
		int                       r;
		logic [CMD_WIDTH-1:0]     cmd;
		logic signed [IO_VAL_WIDTH-1:0] value;
		r     = $urandom_range(0, 99);
		value = $urandom;	// pops ignore it, but vary it anyway
		// Now and then flip between idling and a stretch without gaps
		if ($urandom_range(0, 49) == 0)
			steady = ~steady;
		case (mix)
			MIX_FILL:  r = (r < 88) ? 0 : (r < 92) ? 40 : (r < 96) ? 70 : 85;
			MIX_DRAIN: r = (r < 85) ? 40 : (r < 90) ? 0 : (r < 95) ? 70 : 85;
			default: begin
			end
		endcase
		if (r < 35) begin
			cmd   = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
			value = pick_value();
		end else if (r < 65) begin
			cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
		end else if (r < 80) begin
			cmd   = CMD_REMOVE;
			value = pick_target();
		end else if (r < 95) begin
			cmd   = CMD_CONTAINS;
			value = pick_target();
		end else begin
			cmd = $urandom_range(0, 1) ? CMD_SPARE_7 : CMD_SPARE_6;
		end
		send_item(cmd, value);
		random_items++;
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		board = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty store: pops report empty, searches miss
		send_item(CMD_POP_BACK, 32'sd0);
		send_item(CMD_POP_FRONT, -32'sd1);
		send_item(CMD_REMOVE, 32'sd5);
		send_item(CMD_CONTAINS, 32'sd5);
		// Push at the front of an empty store, then build -1 min max 0 42 7 42
		send_item(CMD_PUSH_FRONT, 32'sh8000_0000);
		send_item(CMD_PUSH_BACK, 32'sh7fff_ffff);
		send_item(CMD_PUSH_BACK, 32'sd0);
		send_item(CMD_PUSH_FRONT, -32'sd1);
		send_item(CMD_PUSH_BACK, 32'sd42);
		send_item(CMD_PUSH_BACK, 32'sd7);
		send_item(CMD_PUSH_BACK, 32'sd42);
		send_item(CMD_CONTAINS, 32'sh7fff_ffff);
		send_item(CMD_CONTAINS, 32'sd12345);
		// Remove from the middle, then the first of two equal values
		send_item(CMD_REMOVE, 32'sh7fff_ffff);
		send_item(CMD_REMOVE, 32'sd42);
		send_item(CMD_CONTAINS, 32'sd42);
		send_item(CMD_REMOVE, 32'sd99);
		// Unused codes change nothing
		send_item(CMD_SPARE_6, 32'sd7);
		send_item(CMD_SPARE_7, 32'sh5555_aaaa);
		send_item(CMD_POP_BACK, 32'sd0);
		send_item(CMD_POP_FRONT, 32'sd0);
		// Remove at the front, then drain past empty
		send_item(CMD_REMOVE, 32'sh8000_0000);
		send_item(CMD_POP_FRONT, 32'sd0);
		send_item(CMD_POP_BACK, 32'sd0);
		send_item(CMD_POP_BACK, 32'sd0);

		// Fill past full, drain past empty, then run a balanced mix
		while (board.shadow.size() < DEPTH)
			random_item(MIX_FILL);
		repeat (8) random_item(MIX_FILL);
		while (board.shadow.size() > 0)
			random_item(MIX_DRAIN);
		repeat (6) random_item(MIX_DRAIN);
		while (random_items < RANDOM_ITEMS)
			random_item(MIX_BALANCED);
		s_tvalid <= 1'b0;

		// Let every awaited result arrive, then watch for strays
		while (board.awaited.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("PASS bounded_deque_with_search");
		else
			$display("FAIL bounded_deque_with_search");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Master side: hold tready high for a run, then drop it for a gap
	// ------------------------------------------------------------------------
	initial begin
		int run;
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			run = $urandom_range(1, 12);
			gap = pick_gap();
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// Check every accepted result item
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata);
	end

	// Watchdog: end the run if no item moves on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL bounded_deque_with_search");
			$finish;
		end
	end

endmodule

FILE: filelist.f
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_ram.sv
hw/rtl/bounded_deque_with_search.sv
sim/tb_bounded_deque_with_search.sv
